FILE: design/mbid_pkg.sv
// shared constants, types and helpers for the multi-button debouncer
package mbid_pkg;

    localparam int NUM_BUTTONS = 8;
    localparam int COUNT_WIDTH = 8;
    localparam int COUNT_MAX   = (1 << COUNT_WIDTH) - 1;

    localparam int NUM_THR     = 8;
    localparam int THR_W       = 8;
    localparam int MASK_W      = 8;
    localparam int CFG_INDEX_W = 4;
    localparam int CFG_DATA_W  = 8;

    localparam logic [THR_W-1:0] THR_RESET = 8'd10;

    // request codes
    localparam logic REQ_TICK = 1'b0;
    localparam logic REQ_INIT = 1'b1;

    typedef logic [COUNT_WIDTH-1:0] count_t;
    typedef logic [THR_W-1:0] thr_t;
    typedef logic [NUM_THR-1:0][THR_W-1:0] thr_bank_t;
    typedef logic [MASK_W-1:0] mask_t;

    typedef struct packed {
        logic fire;
        logic req;
        logic pin;
        logic clr_rise;
        logic clr_fall;
    } lane_ctrl_t;

    typedef struct packed {
        logic level;
        logic rise_lat;
        logic fall_lat;
        logic rise_ev;
        logic fall_ev;
    } lane_out_t;

    // threshold above the counter range saturates at the largest count
    function automatic count_t clamp_thr(input thr_t thr);
        logic [31:0] t;
        t = 32'(thr);
        if (t > 32'(COUNT_MAX)) begin
            return count_t'(COUNT_MAX);
        end
        return count_t'(t);
    endfunction

endpackage

FILE: design/mbid_cfg.sv
// threshold register bank written through the configuration channel
module mbid_cfg (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 cfg_valid,
    output logic                                 cfg_ready,
    input  logic [mbid_pkg::CFG_INDEX_W-1:0]     cfg_index,
    input  logic [mbid_pkg::CFG_DATA_W-1:0]      cfg_data,
    output mbid_pkg::thr_bank_t                  thr
);

    mbid_pkg::thr_bank_t thr_reg;

    assign cfg_ready = 1'b1;
    assign thr       = thr_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < mbid_pkg::NUM_THR; i++) begin
                thr_reg[i] <= mbid_pkg::THR_RESET;
            end
        end else if (cfg_valid && cfg_ready) begin
            // indexes beyond the bank are dropped
            for (int i = 0; i < mbid_pkg::NUM_THR; i++) begin
                if (cfg_index == mbid_pkg::CFG_INDEX_W'(i)) begin
                    thr_reg[i] <= mbid_pkg::thr_t'(cfg_data);
                end
            end
        end
    end

endmodule

FILE: design/mbid_lane.sv
// one button lane: integrating counter, debounced level and edge latches
module mbid_lane (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  mbid_pkg::lane_ctrl_t ctrl,
    input  mbid_pkg::thr_t       thr,
    output mbid_pkg::lane_out_t  res
);

    mbid_pkg::count_t count_reg, count_next;
    mbid_pkg::count_t thr_c;
    logic level_reg, level_next;
    logic rise_reg, fall_reg;
    logic rise_ev, fall_ev;
    logic rise_lat, fall_lat;

    assign thr_c = mbid_pkg::clamp_thr(thr);

    always_comb begin
        count_next = count_reg;
        level_next = level_reg;
        rise_ev    = 1'b0;
        fall_ev    = 1'b0;
        priority if (ctrl.req == mbid_pkg::REQ_INIT) begin
            level_next = ctrl.pin;
            count_next = ctrl.pin ? thr_c : '0;
        end else if (ctrl.pin) begin
            if (count_reg < thr_c) begin
                count_next = mbid_pkg::count_t'(count_reg + 1'b1);
            end else begin
                rise_ev    = !level_reg;
                level_next = 1'b1;
            end
        end else begin
            if (count_reg != '0) begin
                count_next = mbid_pkg::count_t'(count_reg - 1'b1);
            end else begin
                fall_ev    = level_reg;
                level_next = 1'b0;
            end
        end
        // init clears both latches
        rise_lat = (ctrl.req == mbid_pkg::REQ_INIT) ? 1'b0 : (rise_reg | rise_ev);
        fall_lat = (ctrl.req == mbid_pkg::REQ_INIT) ? 1'b0 : (fall_reg | fall_ev);
    end

    assign res.level    = level_next;
    assign res.rise_lat = rise_lat;
    assign res.fall_lat = fall_lat;
    assign res.rise_ev  = rise_ev;
    assign res.fall_ev  = fall_ev;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
            level_reg <= 1'b0;
            rise_reg  <= 1'b0;
            fall_reg  <= 1'b0;
        end else if (ctrl.fire) begin
            count_reg <= count_next;
            level_reg <= level_next;
            rise_reg  <= rise_lat & !ctrl.clr_rise;
            fall_reg  <= fall_lat & !ctrl.clr_fall;
        end
    end

endmodule

FILE: design/multi_button_integrating_debouncer.sv
// top level: input register, per-button lanes, result register
// an accepted item waits in the input register, then moves into the result register
// throughput: one item per cycle while the result slot is free or m_ready is high
// the input register refills while a finished result waits on m_ready
// reset (synchronous, active low): counters, levels and latches clear,
// thresholds return to 10, both channels empty
module multi_button_integrating_debouncer (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             s_valid,
    output logic                             s_ready,
    input  logic                             s_req_type,
    input  logic [mbid_pkg::MASK_W-1:0]      s_pin_levels,
    input  logic [mbid_pkg::MASK_W-1:0]      s_clear_rising,
    input  logic [mbid_pkg::MASK_W-1:0]      s_clear_falling,
    output logic                             m_valid,
    input  logic                             m_ready,
    output logic [mbid_pkg::MASK_W-1:0]      m_debounced_levels,
    output logic [mbid_pkg::MASK_W-1:0]      m_rising_latched,
    output logic [mbid_pkg::MASK_W-1:0]      m_falling_latched,
    output logic [mbid_pkg::MASK_W-1:0]      m_rising_events,
    output logic [mbid_pkg::MASK_W-1:0]      m_falling_events,
    input  logic                             cfg_valid,
    output logic                             cfg_ready,
    input  logic [mbid_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [mbid_pkg::CFG_DATA_W-1:0]  cfg_data
);

    mbid_pkg::thr_bank_t thr;

    logic            in_valid_reg;
    logic            req_reg;
    mbid_pkg::mask_t pins_reg;
    mbid_pkg::mask_t clr_r_reg;
    mbid_pkg::mask_t clr_f_reg;

    logic            out_valid_reg;
    mbid_pkg::mask_t level_out_reg;
    mbid_pkg::mask_t rise_lat_out_reg;
    mbid_pkg::mask_t fall_lat_out_reg;
    mbid_pkg::mask_t rise_ev_out_reg;
    mbid_pkg::mask_t fall_ev_out_reg;

    mbid_pkg::mask_t level_next, rise_lat_next, fall_lat_next;
    mbid_pkg::mask_t rise_ev_next, fall_ev_next;

    logic fire;

    // held item moves into the result register when that slot is free
    assign fire    = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || fire;

    mbid_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .thr       (thr)
    );

    for (genvar i = 0; i < mbid_pkg::NUM_BUTTONS; i++) begin : g_lane
        mbid_pkg::lane_ctrl_t ctrl;
        mbid_pkg::lane_out_t  res;

        assign ctrl.fire     = fire;
        assign ctrl.req      = req_reg;
        assign ctrl.pin      = pins_reg[i];
        assign ctrl.clr_rise = clr_r_reg[i];
        assign ctrl.clr_fall = clr_f_reg[i];

        mbid_lane u_lane (
            .aclk    (aclk),
            .aresetn (aresetn),
            .ctrl    (ctrl),
            .thr     (thr[i]),
            .res     (res)
        );

        assign level_next[i]    = res.level;
        assign rise_lat_next[i] = res.rise_lat;
        assign fall_lat_next[i] = res.fall_lat;
        assign rise_ev_next[i]  = res.rise_ev;
        assign fall_ev_next[i]  = res.fall_ev;
    end

    // lanes that are not built report zero
    for (genvar i = mbid_pkg::NUM_BUTTONS; i < mbid_pkg::MASK_W; i++) begin : g_unused
        assign level_next[i]    = 1'b0;
        assign rise_lat_next[i] = 1'b0;
        assign fall_lat_next[i] = 1'b0;
        assign rise_ev_next[i]  = 1'b0;
        assign fall_ev_next[i]  = 1'b0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                in_valid_reg <= 1'b1;
            end else if (fire) begin
                in_valid_reg <= 1'b0;
            end
            if (fire) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            req_reg   <= s_req_type;
            pins_reg  <= s_pin_levels;
            clr_r_reg <= s_clear_rising;
            clr_f_reg <= s_clear_falling;
        end
        if (fire) begin
            level_out_reg    <= level_next;
            rise_lat_out_reg <= rise_lat_next;
            fall_lat_out_reg <= fall_lat_next;
            rise_ev_out_reg  <= rise_ev_next;
            fall_ev_out_reg  <= fall_ev_next;
        end
    end

    assign m_valid            = out_valid_reg;
    assign m_debounced_levels = level_out_reg;
    assign m_rising_latched   = rise_lat_out_reg;
    assign m_falling_latched  = fall_lat_out_reg;
    assign m_rising_events    = rise_ev_out_reg;
    assign m_falling_events   = fall_ev_out_reg;

endmodule

FILE: design/mbid_checker.sv
// port-level checker for the multi-button debouncer, bound to the top level
module mbid_checker (
    input logic                        aclk,
    input logic                        aresetn,
    input logic                        m_valid,
    input logic                        m_ready,
    input logic [mbid_pkg::MASK_W-1:0] m_debounced_levels,
    input logic [mbid_pkg::MASK_W-1:0] m_rising_latched,
    input logic [mbid_pkg::MASK_W-1:0] m_falling_latched,
    input logic [mbid_pkg::MASK_W-1:0] m_rising_events,
    input logic [mbid_pkg::MASK_W-1:0] m_falling_events
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_debounced_levels)
            && $stable(m_rising_latched) && $stable(m_falling_latched)
            && $stable(m_rising_events) && $stable(m_falling_events))
        else $error("result changed while stalled");

    // every rising event is latched and leaves the level high
    a_rise_ev: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> ((m_rising_events & ~m_rising_latched) == '0)
            && ((m_rising_events & ~m_debounced_levels) == '0))
        else $error("rising event without latch or high level");

    // every falling event is latched and leaves the level low
    a_fall_ev: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> ((m_falling_events & ~m_falling_latched) == '0)
            && ((m_falling_events & m_debounced_levels) == '0))
        else $error("falling event without latch or low level");

    // a button cannot rise and fall on the same tick
    a_ev_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> ((m_rising_events & m_falling_events) == '0))
        else $error("rising and falling event on one button");

    // no result is shown right after reset
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid after reset");

endmodule

bind multi_button_integrating_debouncer mbid_checker u_mbid_checker (.*);
